// ===== hdl/cbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting Bloom filter package
// Field widths, codes, defaults and elaboration-time helpers shared by the
// counting Bloom filter modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int MODE_W    = 2;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 3;
  localparam int FIELDS    = 4;

  localparam int NUM_BUCKETS = 4096;
  localparam int HASHES      = 4;

  localparam logic [CNT_W-1:0] CNT_MAX   = 4'd15;
  localparam logic [CFG_W-1:0] HASH_RST  = 3'd4;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FAIL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd2;

  // Number of conditional subtract steps that bring an index field below n.
  function automatic int red_steps(input int n);
    int s;
    s = 0;
    for (int i = 0; i < 32; i++) begin
      if ((longint'(n) << i) <= longint'((1 << IDX_W) - 1)) begin
        s = i + 1;
      end
    end
    return s;
  endfunction

endpackage

// ===== hdl/cbf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting Bloom filter channels
// Valid/ready channels for operation requests, results and the hash count
// register.
// ----------------------------------------------------------------------------
interface cbf_in_if;
  logic                         valid;
  logic                         ready;
  logic [cbf_pkg::MODE_W-1:0]   mode;
  logic [cbf_pkg::IDX_W-1:0]    bucket_index_0;
  logic [cbf_pkg::IDX_W-1:0]    bucket_index_1;
  logic [cbf_pkg::IDX_W-1:0]    bucket_index_2;
  logic [cbf_pkg::IDX_W-1:0]    bucket_index_3;

  modport source (output valid, mode, bucket_index_0, bucket_index_1, bucket_index_2,
                  bucket_index_3, input ready);
  modport sink   (input valid, mode, bucket_index_0, bucket_index_1, bucket_index_2,
                  bucket_index_3, output ready);
endinterface

interface cbf_out_if;
  logic                          valid;
  logic                          ready;
  logic [cbf_pkg::STATUS_W-1:0]  status;
  logic [cbf_pkg::CNT_W-1:0]     estimated_count;

  modport source (output valid, status, estimated_count, input ready);
  modport sink   (input valid, status, estimated_count, output ready);
endinterface

interface cbf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cbf_pkg::CFG_W-1:0]  active_hashes;

  modport source (output valid, active_hashes, input ready);
  modport sink   (input valid, active_hashes, output ready);
endinterface

// ===== hdl/cbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// One read or write port, registered read data.
// ----------------------------------------------------------------------------
module cbf_ram #(
  parameter int Width = cbf_pkg::CNT_W,
  parameter int Depth = cbf_pkg::NUM_BUCKETS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/counting_bloom_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting Bloom filter
// Store of 4-bit counters addressed by pre-hashed bucket indices: add,
// query and delete with saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one request: mode (add, query, delete) and four bucket
//          indices, each reduced modulo NumBuckets. Only the first k are used,
//          k being active_hashes clamped to 1 .. min(4, Hashes).
//   res_o  returns one result per request: status and the minimum addressed
//          counter before the operation.
//   cfg_i  writes active_hashes; write it only while no request is in flight.
// Timing: one request at a time. The counters live in a single-port memory,
//   so a request reads its k counters one per cycle, then, when counters
//   change, writes them back one per cycle. The result is registered in the
//   same cycle that in_i.ready rises; the memory is free of in-flight state
//   when in_i.ready rises.
// Reset: active_hashes returns to 4 and the memory is cleared one entry a
//   cycle, with in_i.ready low meanwhile.
// Stall: a result waits in the output register; a later result waits in the
//   sequencer until that register empties, holding off further requests.
// ----------------------------------------------------------------------------
module counting_bloom_filter #(
  parameter int NumBuckets = cbf_pkg::NUM_BUCKETS,
  parameter int Hashes     = cbf_pkg::HASHES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbf_in_if.sink    in_i,
  cbf_out_if.source res_o,
  cbf_cfg_if.sink   cfg_i
);

  localparam int AW       = $clog2(NumBuckets);
  localparam int KMax     = (Hashes < cbf_pkg::FIELDS) ? Hashes : cbf_pkg::FIELDS;
  localparam int RedSteps = cbf_pkg::red_steps(NumBuckets);
  localparam int PW       = $clog2(cbf_pkg::FIELDS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 clr_q;
  logic [cbf_pkg::CFG_W-1:0]     hashes_q;
  logic [2:0]                    k_q;
  logic [2:0]                    k_use;
  logic [2:0]                    rd_ptr_q, wr_ptr_q;
  logic                          cap_vld_q;
  logic [PW-1:0]                 cap_ptr_q;

  logic [cbf_pkg::MODE_W-1:0]    mode_q;
  logic [cbf_pkg::IDX_W-1:0]     raw_q   [cbf_pkg::FIELDS];
  logic [AW-1:0]                 addr_q  [cbf_pkg::FIELDS];
  logic [cbf_pkg::CNT_W-1:0]     cnt_q   [cbf_pkg::FIELDS];
  logic [cbf_pkg::CNT_W-1:0]     new_q   [cbf_pkg::FIELDS];
  logic [cbf_pkg::STATUS_W-1:0]  status_q;
  logic [cbf_pkg::CNT_W-1:0]     est_q;

  logic                          out_vld_q;
  logic [cbf_pkg::STATUS_W-1:0]  out_status_q;
  logic [cbf_pkg::CNT_W-1:0]     out_est_q;

  logic [cbf_pkg::IDX_W-1:0]     red;
  logic [AW-1:0]                 rd_addr;
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [cbf_pkg::CNT_W-1:0]     ram_wdata;
  logic [cbf_pkg::CNT_W-1:0]     ram_rdata;

  logic [cbf_pkg::CNT_W-1:0]     min_before, min_after;
  logic                          full;
  logic [2:0]                    mult    [cbf_pkg::FIELDS];
  logic [cbf_pkg::CNT_W-1:0]     inc_val [cbf_pkg::FIELDS];
  logic [cbf_pkg::CNT_W-1:0]     dec_val [cbf_pkg::FIELDS];
  logic [cbf_pkg::STATUS_W-1:0]  status_c;
  logic                          do_write;
  logic                          in_acc, out_free;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_vld_q || res_o.ready;

  assign res_o.valid           = out_vld_q;
  assign res_o.status          = out_status_q;
  assign res_o.estimated_count = out_est_q;

  // clamp the configured hash count to 1 .. KMax
  always_comb begin
    k_use = hashes_q;
    if (hashes_q == 3'd0) begin
      k_use = 3'd1;
    end else if (hashes_q > 3'(KMax)) begin
      k_use = 3'(KMax);
    end
  end

  // reduce the current index field modulo NumBuckets by shifted subtracts
  always_comb begin
    red = raw_q[rd_ptr_q[PW-1:0]];
    for (int s = RedSteps - 1; s >= 0; s--) begin
      if (32'(red) >= (32'(NumBuckets) << s)) begin
        red = red - cbf_pkg::IDX_W'(32'(NumBuckets) << s);
      end
    end
  end

  assign rd_addr = AW'(red);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = new_q[wr_ptr_q[PW-1:0]];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = addr_q[wr_ptr_q[PW-1:0]];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cbf_ram #(
    .Width (cbf_pkg::CNT_W),
    .Depth (NumBuckets)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Duplicate indices act once per occurrence, so each counter moves by its
  // multiplicity and every copy writes back the same final value.
  always_comb begin
    min_before = cbf_pkg::CNT_MAX;
    min_after  = cbf_pkg::CNT_MAX;
    full       = 1'b0;
    for (int i = 0; i < cbf_pkg::FIELDS; i++) begin
      mult[i] = 3'd0;
      for (int j = 0; j < cbf_pkg::FIELDS; j++) begin
        if (3'(j) < k_q && addr_q[j] == addr_q[i]) begin
          mult[i] = mult[i] + 3'd1;
        end
      end
      if (5'(cnt_q[i]) + 5'(mult[i]) > 5'(cbf_pkg::CNT_MAX)) begin
        inc_val[i] = cbf_pkg::CNT_MAX;
      end else begin
        inc_val[i] = cnt_q[i] + cbf_pkg::CNT_W'(mult[i]);
      end
      if (5'(cnt_q[i]) <= 5'(mult[i])) begin
        dec_val[i] = '0;
      end else begin
        dec_val[i] = cnt_q[i] - cbf_pkg::CNT_W'(mult[i]);
      end
      if (3'(i) < k_q) begin
        if (cnt_q[i] < min_before) begin
          min_before = cnt_q[i];
        end
        if (dec_val[i] < min_after) begin
          min_after = dec_val[i];
        end
        if (cnt_q[i] == cbf_pkg::CNT_MAX) begin
          full = 1'b1;
        end
      end
    end

    status_c = cbf_pkg::STAT_OK;
    do_write = 1'b0;
    if (mode_q == cbf_pkg::MODE_ADD) begin
      if (full) begin
        status_c = cbf_pkg::STAT_FAIL;
      end else begin
        do_write = 1'b1;
      end
    end else if (mode_q == cbf_pkg::MODE_DEL) begin
      if (min_before == '0) begin
        status_c = cbf_pkg::STAT_FAIL;
      end else begin
        do_write = 1'b1;
        status_c = (min_after != '0) ? cbf_pkg::STAT_PRESENT : cbf_pkg::STAT_OK;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(NumBuckets - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (cap_vld_q && 3'(cap_ptr_q) == k_q - 3'd1) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = do_write ? ST_WRITE : ST_DONE;
      end
      ST_WRITE: begin
        if (wr_ptr_q == k_q - 3'd1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      hashes_q  <= cbf_pkg::HASH_RST;
      k_q       <= 3'd1;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cap_vld_q <= 1'b0;
      cap_ptr_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        hashes_q <= cfg_i.active_hashes;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (in_acc) begin
        k_q      <= k_use;
        rd_ptr_q <= '0;
      end
      // issue one read a cycle, capture its data in the following cycle
      cap_vld_q <= (state_q == ST_READ) && (rd_ptr_q < k_q);
      if (state_q == ST_READ && rd_ptr_q < k_q) begin
        rd_ptr_q  <= rd_ptr_q + 3'd1;
        cap_ptr_q <= rd_ptr_q[PW-1:0];
      end
      if (state_q == ST_CALC) begin
        wr_ptr_q <= '0;
      end else if (state_q == ST_WRITE) begin
        wr_ptr_q <= wr_ptr_q + 3'd1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= in_i.mode;
      raw_q[0] <= in_i.bucket_index_0;
      raw_q[1] <= in_i.bucket_index_1;
      raw_q[2] <= in_i.bucket_index_2;
      raw_q[3] <= in_i.bucket_index_3;
    end
    if (state_q == ST_READ && rd_ptr_q < k_q) begin
      addr_q[rd_ptr_q[PW-1:0]] <= rd_addr;
    end
    if (cap_vld_q) begin
      cnt_q[cap_ptr_q] <= ram_rdata;
    end
    if (state_q == ST_CALC) begin
      status_q <= status_c;
      est_q    <= min_before;
      for (int i = 0; i < cbf_pkg::FIELDS; i++) begin
        new_q[i] <= (mode_q == cbf_pkg::MODE_ADD) ? inc_val[i] : dec_val[i];
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_status_q <= status_q;
      out_est_q    <= est_q;
    end
  end

endmodule
